>>> rtl/cso_pkg.sv
// cso_pkg: shared widths, register indexes, sprite codes and the arrow bitmap
// for the cursor overlay; no dependencies

package cso_pkg;

    localparam int COL_W  = 10;
    localparam int ROW_W  = 9;
    localparam int PIX_W  = 32;
    localparam int CFG_W  = 12;
    // offset width: a pixel coordinate minus a signed 12-bit origin
    localparam int DIFF_W = CFG_W + 1;

    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int SPRITE_ROWS = 12;
    localparam int SPRITE_COLS = 9;
    localparam int SROW_W = $clog2(SPRITE_ROWS);
    localparam int SCOL_W = $clog2(SPRITE_COLS);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_COL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ROW = 1'b1;

    localparam logic signed [CFG_W-1:0] CURSOR_COL_RST = 12'sd320;
    localparam logic signed [CFG_W-1:0] CURSOR_ROW_RST = 12'sd240;

    localparam logic [PIX_W-1:0] COLOR_BLACK = 32'h0000_0000;
    localparam logic [PIX_W-1:0] COLOR_WHITE = 32'h00FF_FFFF;

    typedef enum logic [1:0] {
        CODE_CLEAR = 2'd0,
        CODE_BLACK = 2'd1,
        CODE_WHITE = 2'd2
    } code_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] col;
        logic signed [CFG_W-1:0] row;
    } cursor_t;

    localparam code_t ARROW_CODES [0:SPRITE_ROWS-1][0:SPRITE_COLS-1] = '{
        '{CODE_BLACK, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR,
          CODE_CLEAR, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR},
        '{CODE_BLACK, CODE_BLACK, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR,
          CODE_CLEAR, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR},
        '{CODE_BLACK, CODE_WHITE, CODE_BLACK, CODE_CLEAR, CODE_CLEAR,
          CODE_CLEAR, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR},
        '{CODE_BLACK, CODE_WHITE, CODE_WHITE, CODE_BLACK, CODE_CLEAR,
          CODE_CLEAR, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR},
        '{CODE_BLACK, CODE_WHITE, CODE_WHITE, CODE_WHITE, CODE_BLACK,
          CODE_CLEAR, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR},
        '{CODE_BLACK, CODE_WHITE, CODE_WHITE, CODE_WHITE, CODE_WHITE,
          CODE_BLACK, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR},
        '{CODE_BLACK, CODE_WHITE, CODE_WHITE, CODE_WHITE, CODE_WHITE,
          CODE_WHITE, CODE_BLACK, CODE_CLEAR, CODE_CLEAR},
        '{CODE_BLACK, CODE_WHITE, CODE_WHITE, CODE_WHITE, CODE_WHITE,
          CODE_WHITE, CODE_WHITE, CODE_BLACK, CODE_CLEAR},
        '{CODE_BLACK, CODE_WHITE, CODE_WHITE, CODE_WHITE, CODE_BLACK,
          CODE_BLACK, CODE_BLACK, CODE_BLACK, CODE_BLACK},
        '{CODE_BLACK, CODE_WHITE, CODE_BLACK, CODE_WHITE, CODE_BLACK,
          CODE_CLEAR, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR},
        '{CODE_BLACK, CODE_BLACK, CODE_CLEAR, CODE_BLACK, CODE_WHITE,
          CODE_BLACK, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR},
        '{CODE_BLACK, CODE_CLEAR, CODE_CLEAR, CODE_BLACK, CODE_BLACK,
          CODE_CLEAR, CODE_CLEAR, CODE_CLEAR, CODE_CLEAR}
    };

endpackage

>>> rtl/cso_pixel_if.sv
// cso_pixel_if: scanned-out pixel channel (coordinates and back-buffer color)
// depends on cso_pkg for field widths

interface cso_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [cso_pkg::COL_W-1:0] pixel_col;
    logic [cso_pkg::ROW_W-1:0] pixel_row;
    logic [cso_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_col, output pixel_row,
                    output pixel_in, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row,
                    input pixel_in, output ready);
endinterface

>>> rtl/cso_color_if.sv
// cso_color_if: displayed color channel out of the cursor overlay
// depends on cso_pkg for field widths

interface cso_color_if;
    logic                      valid;
    logic                      ready;
    logic [cso_pkg::PIX_W-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

>>> rtl/cursor_sprite_overlay.sv
// cursor_sprite_overlay: arrow cursor overlay on the scan-out pixel stream
// depends on cso_pkg, cso_pixel_if, cso_color_if and cso_overlay_pipe
//
//  channel        dir  handshake      payload
//  pixel_stream   in   valid/ready    pixel_col[9:0], pixel_row[8:0], pixel_in[31:0]
//  display_stream out  valid/ready    pixel_out[31:0]
//  cfg            in   cfg_we         cfg_index[0], cfg_data[11:0]
//
// one pixel per cycle sustained while display_stream is ready; each pixel passes
// through the offset subtract, sprite table lookup and color select registers in
// that order, and its result is offered on display_stream from the last of them
// the three pipeline stages each carry a valid bit; back-pressure stalls only
// as far as the first empty stage, so nothing is dropped or repeated
// reset gives an empty pipeline and the cursor origin at column 320, row 240

module cursor_sprite_overlay #(
    parameter int SCREEN_WIDTH  = cso_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = cso_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cso_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cso_pkg::CFG_W-1:0]     cfg_data,
    cso_pixel_if.sink                     pixel_stream,
    cso_color_if.source                   display_stream
);

    cso_pkg::cursor_t cursor_reg;
    cso_pkg::cursor_t cursor_next;

    always_comb
    begin
        cursor_next = cursor_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cso_pkg::REG_CURSOR_COL: cursor_next.col = signed'(cfg_data);
                cso_pkg::REG_CURSOR_ROW: cursor_next.row = signed'(cfg_data);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg.col <= cso_pkg::CURSOR_COL_RST;
            cursor_reg.row <= cso_pkg::CURSOR_ROW_RST;
        end
        else
        begin
            cursor_reg <= cursor_next;
        end
    end

    cso_overlay_pipe #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_pipe (
        .clk    (clk),
        .rst_n  (rst_n),
        .cursor (cursor_reg),
        .pixels (pixel_stream),
        .colors (display_stream)
    );

endmodule

>>> rtl/cso_overlay_pipe.sv
// cso_overlay_pipe: three-stage pixel pipeline (offset, sprite lookup, color select)
// depends on cso_pkg, cso_pixel_if and cso_color_if

module cso_overlay_pipe #(
    parameter int SCREEN_WIDTH  = cso_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = cso_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cso_pkg::cursor_t cursor,
    cso_pixel_if.sink        pixels,
    cso_color_if.source      colors
);

    localparam int DW = cso_pkg::DIFF_W;
    localparam logic [DW-1:0] SCR_W_LIM  = DW'(SCREEN_WIDTH);
    localparam logic [DW-1:0] SCR_H_LIM  = DW'(SCREEN_HEIGHT);
    localparam logic [DW-1:0] SPR_C_LIM  = DW'(cso_pkg::SPRITE_COLS);
    localparam logic [DW-1:0] SPR_R_LIM  = DW'(cso_pkg::SPRITE_ROWS);

    // stage enables: a stage loads when empty or when its content moves on
    logic en1, en2, en3;

    // stage 1: offsets from the cursor origin
    logic                      s1_valid_reg;
    logic signed [DW-1:0]      s1_dx_reg, s1_dy_reg;
    logic                      s1_onscreen_reg;
    logic [cso_pkg::PIX_W-1:0] s1_pixel_reg;
    logic signed [DW-1:0]      s1_dx_next, s1_dy_next;
    logic                      s1_onscreen_next;

    // stage 2: sprite code
    logic                      s2_valid_reg;
    cso_pkg::code_t            s2_code_reg;
    logic [cso_pkg::PIX_W-1:0] s2_pixel_reg;
    cso_pkg::code_t            s2_code_next;
    logic                      s2_inside;

    // stage 3: output register
    logic                      s3_valid_reg;
    logic [cso_pkg::PIX_W-1:0] s3_pixel_reg;
    logic [cso_pkg::PIX_W-1:0] s3_pixel_next;

    assign en3 = !s3_valid_reg || colors.ready;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign pixels.ready = en1;

    always_comb
    begin
        s1_dx_next = signed'({{(DW - cso_pkg::COL_W){1'b0}}, pixels.pixel_col})
                   - signed'({cursor.col[cso_pkg::CFG_W-1], cursor.col});
        s1_dy_next = signed'({{(DW - cso_pkg::ROW_W){1'b0}}, pixels.pixel_row})
                   - signed'({cursor.row[cso_pkg::CFG_W-1], cursor.row});
        s1_onscreen_next =
            ({{(DW - cso_pkg::COL_W){1'b0}}, pixels.pixel_col} < SCR_W_LIM) &&
            ({{(DW - cso_pkg::ROW_W){1'b0}}, pixels.pixel_row} < SCR_H_LIM);
    end

    always_comb
    begin
        s2_inside = s1_onscreen_reg
                 && !s1_dx_reg[DW-1] && (unsigned'(s1_dx_reg) < SPR_C_LIM)
                 && !s1_dy_reg[DW-1] && (unsigned'(s1_dy_reg) < SPR_R_LIM);
        s2_code_next = s2_inside
            ? cso_pkg::ARROW_CODES[s1_dy_reg[cso_pkg::SROW_W-1:0]]
                                  [s1_dx_reg[cso_pkg::SCOL_W-1:0]]
            : cso_pkg::CODE_CLEAR;
    end

    always_comb
    begin
        unique case (s2_code_reg)
            cso_pkg::CODE_BLACK: s3_pixel_next = cso_pkg::COLOR_BLACK;
            cso_pkg::CODE_WHITE: s3_pixel_next = cso_pkg::COLOR_WHITE;
            default:             s3_pixel_next = s2_pixel_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= pixels.valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_dx_reg       <= s1_dx_next;
            s1_dy_reg       <= s1_dy_next;
            s1_onscreen_reg <= s1_onscreen_next;
            s1_pixel_reg    <= pixels.pixel_in;
        end
        if (en2)
        begin
            s2_code_reg  <= s2_code_next;
            s2_pixel_reg <= s1_pixel_reg;
        end
        if (en3)
            s3_pixel_reg <= s3_pixel_next;
    end

    assign colors.valid     = s3_valid_reg;
    assign colors.pixel_out = s3_pixel_reg;

    // input is held off only when every stage is occupied
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixels.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg))
        else $error("input stalled while the pipeline has a free stage");

    // an off-screen pixel never picks up a sprite code
    a_offscreen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (en2 && s1_valid_reg && !s1_onscreen_reg) |=>
            (s2_code_reg == cso_pkg::CODE_CLEAR))
        else $error("off-screen pixel got a cursor code");

    // a stalled result stays in the output stage
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !colors.ready) |=> s3_valid_reg)
        else $error("stalled result dropped");

    // stage 2 content is not overwritten while stage 3 is blocked
    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_valid_reg && !colors.ready) |=>
            (s2_valid_reg && $stable(s2_pixel_reg) && $stable(s2_code_reg)))
        else $error("stage 2 lost its item during a stall");

endmodule
